// ----- rtl/core/smalu_pkg.sv -----
`default_nettype none
package smalu_pkg;

  localparam int DATA_W          = 32;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int DIV_STEPS       = 32;
  localparam int STEP_W          = $clog2(DIV_STEPS);

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [6:0]        level_t;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_OUT     = 3'd5,
    OP_HLT     = 3'd6,
    OP_INVALID = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_OK      = 4'd0,
    ST_OUT     = 4'd1,
    ST_MISSING = 4'd2,
    ST_INVALID = 4'd3,
    ST_UNDER   = 4'd4,
    ST_OVER    = 4'd5,
    ST_DIVZERO = 4'd6,
    ST_HALT    = 4'd7,
    ST_IGNORED = 4'd8
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD_OUT,
    S_RD_TOP,
    S_RD_SEC,
    S_EXEC,
    S_ABS_A,
    S_ABS_B,
    S_DIV,
    S_FIX,
    S_WB,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/stack_machine_alu_unit.sv -----
// Push, halt, invalid and ignored requests go from check to done; out reads the
// top entry; add, sub and mul read both operands, execute and write back; div adds
// absolute-value, divider-loop and fixup states. One request at a time; the radix-2
// divider loop (32 steps through the shared 33-bit adder) is the longest operation.
// Synchronous active-low reset empties the stack, clears halt and drops out_valid;
// stack memory contents are not cleared.
`default_nettype none
module stack_machine_alu_unit #(
  parameter int STACK_DEPTH = smalu_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      in_req_type,
  input  wire logic signed [smalu_pkg::DATA_W-1:0] in_push_value,
  input  wire logic                            in_value_present,
  input  wire logic                            in_last_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [3:0]                           out_status,
  output logic signed [smalu_pkg::DATA_W-1:0]  out_out_value,
  output logic [6:0]                           out_stack_level
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = smalu_pkg::DATA_W;
  localparam int SW = smalu_pkg::STEP_W;

  smalu_pkg::state_t  state_r, state_nxt;
  smalu_pkg::op_t     op_r, op_nxt;
  smalu_pkg::word_t   val_r, val_nxt;
  logic               pres_r, pres_nxt;
  logic               last_r, last_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               halted_r, halted_nxt;
  smalu_pkg::word_t   s_r, s_nxt;
  smalu_pkg::word_t   t_r, t_nxt;
  smalu_pkg::word_t   rem_r, rem_nxt;
  smalu_pkg::word_t   res_r, res_nxt;
  logic               neg_r, neg_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  smalu_pkg::status_t sts_r, sts_nxt;
  smalu_pkg::word_t   emit_r, emit_nxt;
  logic               out_valid_r, out_valid_nxt;
  smalu_pkg::status_t out_sts_r, out_sts_nxt;
  smalu_pkg::word_t   out_val_r, out_val_nxt;
  smalu_pkg::level_t  out_lvl_r, out_lvl_nxt;

  smalu_pkg::word_t   mem [STACK_DEPTH];
  smalu_pkg::word_t   rd_data_r;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  smalu_pkg::word_t   wr_data;

  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      cnt_m2;
  logic [DW:0]        add_a;
  logic [DW:0]        add_b;
  logic               add_cin;
  logic [DW+1:0]      add_sum;
  logic               div_ge;
  smalu_pkg::word_t   mul_lo;

  assign cnt_m1  = cnt_r - CW'(1);
  assign cnt_m2  = cnt_r - CW'(2);
  assign rd_addr = (state_r == smalu_pkg::S_CHECK) ? cnt_m1[AW-1:0] : cnt_m2[AW-1:0];
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{(DW+1){1'b0}}, add_cin};
  assign div_ge  = add_sum[DW+1];
  assign mul_lo  = s_r * t_r;

  assign in_ready        = (state_r == smalu_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_sts_r;
  assign out_out_value   = out_val_r;
  assign out_stack_level = out_lvl_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smalu_pkg::S_IDLE: begin
        if (in_valid) state_nxt = smalu_pkg::S_CHECK;
      end
      smalu_pkg::S_CHECK: begin
        state_nxt = smalu_pkg::S_DONE;
        if (!halted_r) begin
          case (op_r)
            smalu_pkg::OP_ADD, smalu_pkg::OP_SUB, smalu_pkg::OP_MUL,
            smalu_pkg::OP_DIV: begin
              if (cnt_r >= CW'(2)) state_nxt = smalu_pkg::S_RD_TOP;
            end
            smalu_pkg::OP_OUT: begin
              if (cnt_r != '0) state_nxt = smalu_pkg::S_RD_OUT;
            end
            default: state_nxt = smalu_pkg::S_DONE;
          endcase
        end
      end
      smalu_pkg::S_RD_OUT: state_nxt = smalu_pkg::S_DONE;
      smalu_pkg::S_RD_TOP: state_nxt = smalu_pkg::S_RD_SEC;
      smalu_pkg::S_RD_SEC: state_nxt = smalu_pkg::S_EXEC;
      smalu_pkg::S_EXEC: begin
        if (op_r == smalu_pkg::OP_DIV) begin
          state_nxt = (t_r == '0) ? smalu_pkg::S_DONE : smalu_pkg::S_ABS_A;
        end else begin
          state_nxt = smalu_pkg::S_WB;
        end
      end
      smalu_pkg::S_ABS_A: state_nxt = smalu_pkg::S_ABS_B;
      smalu_pkg::S_ABS_B: state_nxt = smalu_pkg::S_DIV;
      smalu_pkg::S_DIV: begin
        if (step_r == SW'(smalu_pkg::DIV_STEPS - 1)) state_nxt = smalu_pkg::S_FIX;
      end
      smalu_pkg::S_FIX: state_nxt = smalu_pkg::S_WB;
      smalu_pkg::S_WB:  state_nxt = smalu_pkg::S_DONE;
      smalu_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = smalu_pkg::S_IDLE;
      end
      default: state_nxt = smalu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    val_nxt       = val_r;
    pres_nxt      = pres_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    halted_nxt    = halted_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    sts_nxt       = sts_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sts_nxt   = out_sts_r;
    out_val_nxt   = out_val_r;
    out_lvl_nxt   = out_lvl_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = val_r;
    add_a         = '0;
    add_b         = '0;
    add_cin       = 1'b0;
    case (state_r)
      smalu_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt   = smalu_pkg::op_t'(in_req_type);
          val_nxt  = in_push_value;
          pres_nxt = in_value_present;
          last_nxt = in_last_item;
        end
      end
      smalu_pkg::S_CHECK: begin
        sts_nxt  = smalu_pkg::ST_OK;
        emit_nxt = '0;
        if (halted_r) begin
          sts_nxt = smalu_pkg::ST_IGNORED;
        end else begin
          case (op_r)
            smalu_pkg::OP_PUSH: begin
              if (!pres_r) begin
                sts_nxt = smalu_pkg::ST_MISSING;
              end else if (cnt_r >= CW'(STACK_DEPTH)) begin
                sts_nxt = smalu_pkg::ST_OVER;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            smalu_pkg::OP_ADD, smalu_pkg::OP_SUB, smalu_pkg::OP_MUL,
            smalu_pkg::OP_DIV: begin
              if (cnt_r < CW'(2)) sts_nxt = smalu_pkg::ST_UNDER;
            end
            smalu_pkg::OP_OUT: begin
              if (cnt_r == '0) sts_nxt = smalu_pkg::ST_UNDER;
            end
            smalu_pkg::OP_HLT: begin
              sts_nxt    = smalu_pkg::ST_HALT;
              halted_nxt = 1'b1;
            end
            default: sts_nxt = smalu_pkg::ST_INVALID;
          endcase
        end
      end
      smalu_pkg::S_RD_OUT: begin
        emit_nxt = rd_data_r;
        cnt_nxt  = cnt_m1;
        sts_nxt  = smalu_pkg::ST_OUT;
      end
      smalu_pkg::S_RD_TOP: t_nxt = rd_data_r;
      smalu_pkg::S_RD_SEC: s_nxt = rd_data_r;
      smalu_pkg::S_EXEC: begin
        case (op_r)
          smalu_pkg::OP_ADD: begin
            add_a   = {1'b0, s_r};
            add_b   = {1'b0, t_r};
            res_nxt = add_sum[DW-1:0];
          end
          smalu_pkg::OP_SUB: begin
            add_a   = {1'b0, s_r};
            add_b   = {1'b0, ~t_r};
            add_cin = 1'b1;
            res_nxt = add_sum[DW-1:0];
          end
          smalu_pkg::OP_MUL: res_nxt = mul_lo;
          default: begin
            neg_nxt = s_r[DW-1] ^ t_r[DW-1];
            if (t_r == '0) sts_nxt = smalu_pkg::ST_DIVZERO;
          end
        endcase
      end
      smalu_pkg::S_ABS_A: begin
        add_b    = {1'b0, ~s_r};
        add_cin  = 1'b1;
        rem_nxt  = '0;
        step_nxt = '0;
        if (s_r[DW-1]) s_nxt = add_sum[DW-1:0];
      end
      smalu_pkg::S_ABS_B: begin
        add_b   = {1'b0, ~t_r};
        add_cin = 1'b1;
        if (t_r[DW-1]) t_nxt = add_sum[DW-1:0];
      end
      smalu_pkg::S_DIV: begin
        add_a    = {rem_r, s_r[DW-1]};
        add_b    = ~{1'b0, t_r};
        add_cin  = 1'b1;
        s_nxt    = {s_r[DW-2:0], div_ge};
        rem_nxt  = div_ge ? add_sum[DW-1:0] : {rem_r[DW-2:0], s_r[DW-1]};
        step_nxt = step_r + SW'(1);
      end
      smalu_pkg::S_FIX: begin
        add_b   = {1'b0, ~s_r};
        add_cin = 1'b1;
        res_nxt = neg_r ? add_sum[DW-1:0] : s_r;
      end
      smalu_pkg::S_WB: begin
        wr_en   = 1'b1;
        wr_addr = cnt_m2[AW-1:0];
        wr_data = res_r;
        cnt_nxt = cnt_m1;
      end
      smalu_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = sts_r;
          out_val_nxt   = emit_r;
          out_lvl_nxt   = smalu_pkg::level_t'(cnt_r);
          if (last_r) begin
            cnt_nxt    = '0;
            halted_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smalu_pkg::S_IDLE;
      cnt_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    pres_r    <= pres_nxt;
    last_r    <= last_nxt;
    s_r       <= s_nxt;
    t_r       <= t_nxt;
    rem_r     <= rem_nxt;
    res_r     <= res_nxt;
    neg_r     <= neg_nxt;
    step_r    <= step_nxt;
    sts_r     <= sts_nxt;
    emit_r    <= emit_nxt;
    out_sts_r <= out_sts_nxt;
    out_val_r <= out_val_nxt;
    out_lvl_r <= out_lvl_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_exec_operands: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == smalu_pkg::S_EXEC |-> cnt_r >= CW'(2))
    else $error("arithmetic with fewer than two entries");

  a_fix_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == smalu_pkg::S_FIX |->
      ($past(state_r) == smalu_pkg::S_DIV &&
       $past(step_r) == SW'(smalu_pkg::DIV_STEPS - 1)))
    else $error("quotient fixup before divider finished");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == smalu_pkg::S_DONE && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == smalu_pkg::S_IDLE))
    else $error("result not loaded on completion");

endmodule
`default_nettype wire
